@@ rtl/sfr_pkg.sv @@
// Shared types and constants of the SBUS frame receiver.
`default_nettype none
package sfr_pkg;

    // Frame layout
    localparam int unsigned FRAME_BYTES   = 25;
    localparam int unsigned CHANNELS      = 16;
    localparam logic [7:0]  SBUS_HEADER   = 8'h0F;
    localparam logic [7:0]  SBUS_FOOTER   = 8'h00;
    localparam logic [4:0]  HDR_IDX       = 5'd0;
    localparam logic [4:0]  FS_IDX        = 5'd23;
    localparam logic [4:0]  FTR_IDX       = 5'd24;
    localparam int unsigned FS_BIT        = 3;
    localparam logic [4:0]  COUNT_FULL    = 5'd25;
    localparam logic [7:0]  BIT_START     = 8'd8;
    localparam logic [7:0]  BITS_PER_CHAN = 8'd11;
    localparam logic [3:0]  CHAN_LAST     = 4'd15;
    localparam logic [1:0]  RD_LAST       = 2'd2;

    // Input action codes
    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_GAP  = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // Register map (word index) and reset values
    localparam logic [1:0]  REG_TIMEOUT  = 2'd0;
    localparam logic [1:0]  REG_CHAN_MIN = 2'd1;
    localparam logic [1:0]  REG_CHAN_MAX = 2'd2;
    localparam logic [15:0] TIMEOUT_RST  = 16'd500;
    localparam logic [10:0] CHAN_MIN_RST = 11'd172;
    localparam logic [10:0] CHAN_MAX_RST = 11'd1811;

    localparam logic [15:0]        MS_SAT  = 16'hFFFF;
    localparam logic signed [15:0] POS_MAX = 16'sh7FFF;
    localparam logic signed [15:0] POS_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         channel;
        logic [10:0]        raw_value;
        logic signed [15:0] position;
        logic               failsafe;
        logic               timed_out;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [10:0] chan_min;
        logic [10:0] chan_max;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic rd;
        logic setup;
        logic div;
        logic fin;
        logic next;
    } t_dp_cmd;

    typedef struct packed {
        logic gap_timed;
        logic gap_good;
        logic run_timed;
        logic rd_last;
        logic div_last;
        logic chan_last;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/sfr_dp.sv @@
// Datapath: frame store, counters, channel unpacking and radix-2 divider.
`default_nettype none
module sfr_dp import sfr_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire t_in_item  i_in_data,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_sts        o_sts,
    output t_out_item      o_out_data
);

    logic [7:0]  r_mem [FRAME_BYTES];
    logic [7:0]  r_rdata;
    logic        r_rd_pend;
    logic [23:0] r_window;

    logic [4:0]  r_byte_count;
    logic [15:0] r_ms;
    logic        r_hdr_ok;
    logic        r_ftr_ok;
    logic        r_frame_fs;

    logic        r_run_timed;
    logic        r_run_fs;
    logic [3:0]  r_chan;
    logic [7:0]  r_bit;
    logic [1:0]  r_rd_cnt;

    logic [10:0] r_raw;
    logic [27:0] r_rem;
    logic [27:0] r_dvs;
    logic [15:0] r_quo;
    logic [3:0]  r_div_cnt;
    logic        r_neg;
    logic        r_ovf;
    logic        r_zden;
    logic        r_a_neg;
    logic        r_a_zero;

    t_out_item   r_out;

    logic               gap_timed;
    logic               gap_good;
    logic [4:0]         rd_addr;
    logic [23:0]        win_shift;
    logic [10:0]        raw;
    logic signed [12:0] num_a;
    logic signed [11:0] den;
    logic [12:0]        an_w;
    logic [11:0]        an;
    logic [11:0]        ad_w;
    logic [10:0]        ad;
    logic [27:0]        dividend;
    logic [27:0]        ovf_lim;
    logic signed [15:0] pos;

    // Gap decision from current state
    assign gap_timed = r_ms > i_cfg.timeout_ms;
    assign gap_good  = (r_byte_count == COUNT_FULL) && r_hdr_ok && r_ftr_ok;

    assign rd_addr = r_bit[7:3] + {3'b000, r_rd_cnt};

    // Unpack one channel from the three-byte window
    assign win_shift = r_window >> r_bit[2:0];
    assign raw       = r_run_timed ? 11'd0 : win_shift[10:0];

    // Normalization numerator and denominator
    assign num_a    = $signed({1'b0, raw, 1'b0}) - $signed({2'b00, i_cfg.chan_max})
                    - $signed({2'b00, i_cfg.chan_min});
    assign den      = $signed({1'b0, i_cfg.chan_max}) - $signed({1'b0, i_cfg.chan_min});
    assign an_w     = num_a[12] ? 13'(-num_a) : 13'(num_a);
    assign an       = an_w[11:0];
    assign ad_w     = den[11] ? 12'(-den) : 12'(den);
    assign ad       = ad_w[10:0];
    assign dividend = {1'b0, an, 15'b0} + {17'b0, ad};
    assign ovf_lim  = {ad, 1'b0, 16'b0};

    // Round, sign and saturate the quotient
    always_comb begin
        if (r_zden) begin
            if (r_a_zero) begin
                pos = 16'sd0;
            end else if (r_a_neg) begin
                pos = POS_MIN;
            end else begin
                pos = POS_MAX;
            end
        end else if (r_neg) begin
            pos = (r_ovf || r_quo[15]) ? POS_MIN : $signed(16'(~r_quo + 16'd1));
        end else begin
            pos = (r_ovf || r_quo[15]) ? POS_MAX : $signed(r_quo);
        end
    end

    // Frame store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_data.action == ACT_BYTE) && (r_byte_count < COUNT_FULL)) begin
            r_mem[r_byte_count] <= i_in_data.data_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control state: counters, run flags, read sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 5'd0;
            r_ms         <= 16'd0;
            r_run_timed  <= 1'b0;
            r_run_fs     <= 1'b0;
            r_chan       <= 4'd0;
            r_bit        <= BIT_START;
            r_rd_cnt     <= 2'd0;
            r_rd_pend    <= 1'b0;
            r_div_cnt    <= 4'd0;
        end else begin
            r_rd_pend <= i_cmd.rd;
            if (i_cmd.take) begin
                case (i_in_data.action)
                    ACT_BYTE: begin
                        if (r_byte_count <= COUNT_FULL) begin
                            r_byte_count <= r_byte_count + 5'd1;
                        end
                    end
                    ACT_TICK: begin
                        if (r_ms != MS_SAT) begin
                            r_ms <= r_ms + 16'd1;
                        end
                    end
                    ACT_GAP: begin
                        r_byte_count <= 5'd0;
                        if (gap_timed || gap_good) begin
                            r_ms        <= 16'd0;
                            r_run_timed <= gap_timed;
                            r_run_fs    <= gap_timed | r_frame_fs;
                            r_chan      <= 4'd0;
                            r_bit       <= BIT_START;
                            r_rd_cnt    <= 2'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.rd) begin
                r_rd_cnt <= r_rd_cnt + 2'd1;
            end
            if (i_cmd.setup) begin
                r_div_cnt <= 4'd15;
            end
            if (i_cmd.div) begin
                r_div_cnt <= r_div_cnt - 4'd1;
            end
            if (i_cmd.next) begin
                r_chan   <= r_chan + 4'd1;
                r_bit    <= r_bit + BITS_PER_CHAN;
                r_rd_cnt <= 2'd0;
            end
        end
    end

    // Payload: frame checks, window, divider, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_data.action == ACT_BYTE)) begin
            if (r_byte_count == HDR_IDX) begin
                r_hdr_ok <= i_in_data.data_byte == SBUS_HEADER;
            end
            if (r_byte_count == FS_IDX) begin
                r_frame_fs <= i_in_data.data_byte[FS_BIT];
            end
            if (r_byte_count == FTR_IDX) begin
                r_ftr_ok <= i_in_data.data_byte == SBUS_FOOTER;
            end
        end
        if (r_rd_pend) begin
            r_window <= {r_rdata, r_window[23:8]};
        end
        if (i_cmd.setup) begin
            r_raw    <= raw;
            r_rem    <= dividend;
            r_dvs    <= {1'b0, ad, 1'b0, 15'b0};
            r_quo    <= 16'd0;
            r_ovf    <= dividend >= ovf_lim;
            r_zden   <= den == 12'sd0;
            r_neg    <= num_a[12] != den[11];
            r_a_neg  <= num_a[12];
            r_a_zero <= num_a == 13'sd0;
        end
        if (i_cmd.div) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_quo <= {r_quo[14:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
        if (i_cmd.fin) begin
            r_out.channel   <= r_chan;
            r_out.raw_value <= r_raw;
            r_out.position  <= pos;
            r_out.failsafe  <= r_run_fs;
            r_out.timed_out <= r_run_timed;
            r_out.last      <= r_chan == CHAN_LAST;
        end
    end

    assign o_sts.gap_timed = gap_timed;
    assign o_sts.gap_good  = gap_good;
    assign o_sts.run_timed = r_run_timed;
    assign o_sts.rd_last   = r_rd_cnt == RD_LAST;
    assign o_sts.div_last  = r_div_cnt == 4'd0;
    assign o_sts.chan_last = r_chan == CHAN_LAST;
    assign o_out_data      = r_out;

endmodule
`default_nettype wire

@@ rtl/sfr_ctrl.sv @@
// Controller: sequences byte reads, division steps and result beats.
`default_nettype none
module sfr_ctrl import sfr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_action,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_SETUP,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if ((i_action == ACT_GAP) && (i_sts.gap_timed || i_sts.gap_good)) begin
                        n_state = i_sts.gap_timed ? ST_SETUP : ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_SETUP;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    o_cmd.next = 1'b1;
                    if (i_sts.chan_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = i_sts.run_timed ? ST_SETUP : ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (o_cmd.next) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/sbus_frame_receiver_unit.sv @@
// Top level of the SBUS frame receiver: register port, controller and datapath.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one action per
// beat: a received byte, a line idle gap or a millisecond tick. Bytes and
// ticks leave the block idle; the next beat is accepted in the following cycle.
// A gap that ends a good 25-byte frame, or that finds the link timed out,
// starts a run of sixteen result beats on the output channel
// (o_out_valid / i_out_stall / o_out_data), one per channel, the last one
// flagged. Each channel costs 3 frame store reads and a read latency wait,
// a setup step, a 16-step shift-subtract divider and a rounding step, then
// a result beat; a timeout run skips the reads. The input stalls for the
// whole run. A stall on the output holds the current result and freezes
// the run. Reset (synchronous, active low) clears the byte and tick
// counters and loads the register defaults; no clearing pass is needed.
// Registers must be written by the user over the APB port only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module sbus_frame_receiver_unit import sfr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms <= TIMEOUT_RST;
            r_cfg.chan_min   <= CHAN_MIN_RST;
            r_cfg.chan_max   <= CHAN_MAX_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TIMEOUT:  r_cfg.timeout_ms <= pwdata[15:0];
                REG_CHAN_MIN: r_cfg.chan_min   <= pwdata[10:0];
                REG_CHAN_MAX: r_cfg.chan_max   <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_TIMEOUT:  prdata = {16'd0, r_cfg.timeout_ms};
            REG_CHAN_MIN: prdata = {21'd0, r_cfg.chan_min};
            REG_CHAN_MAX: prdata = {21'd0, r_cfg.chan_max};
            default:      prdata = 32'd0;
        endcase
    end

    sfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sfr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

`ifndef SYNTH
    // A result beat only exists while the input side is held off
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result valid while input accepted");

    // The last beat of a run returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last) |=> (!o_out_valid && !o_in_stall))
        else $error("run did not end after last beat");

    // Timeout results carry zero raw value and the failsafe flag
    a_timeout_fs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timed_out)
            |-> (o_out_data.failsafe && (o_out_data.raw_value == 11'd0)))
        else $error("timeout result without failsafe or with raw value");

    // Hold a stalled result beat unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");
`endif

endmodule
`default_nettype wire
